[rtl/cascaded_angle_rate_pid_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded angle/rate PID unit
// Clocked assertion helpers for the checker file.
// ----------------------------------------------------------------------------
`ifndef CASCADED_ANGLE_RATE_PID_UNIT_DEFINES_SVH
`define CASCADED_ANGLE_RATE_PID_UNIT_DEFINES_SVH

// check on every edge outside reset
`define CARPID_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every edge, reset included
`define CARPID_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/carpid_pkg.sv]
// ----------------------------------------------------------------------------
// carpid_pkg
// Types, constants and arithmetic helpers of the cascaded angle/rate PID unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package carpid_pkg;

   localparam int GAIN_W    = 24;
   localparam int ANGLE_W   = 16;
   localparam int OUT_W     = 32;
   localparam int OPND_W    = 34;
   localparam int PROD_W    = GAIN_W + OPND_W;
   localparam int ACC_W     = 64;
   localparam int OUTER_SHIFT = 16;
   localparam int INNER_SHIFT = 8;

   localparam logic signed [OPND_W-1:0] RATE_OFFSET = 34'sd12;

   localparam logic signed [15:0] TARGET_ANGLE_RST = -16'sd512;
   localparam logic signed [23:0] ANGLE_P_RST      = 24'sd153600;
   localparam logic signed [23:0] ANGLE_I_RST      = 24'sd0;
   localparam logic signed [23:0] ANGLE_D_RST      = 24'sd0;
   localparam logic signed [23:0] RATE_P_RST       = 24'sd15360;
   localparam logic signed [23:0] RATE_I_RST       = 24'sd3840;
   localparam logic signed [23:0] RATE_D_RST       = 24'sd0;

   typedef enum logic [2:0] {
      CSR_TARGET_ANGLE = 3'd0,
      CSR_ANGLE_P      = 3'd1,
      CSR_ANGLE_I      = 3'd2,
      CSR_ANGLE_D      = 3'd3,
      CSR_RATE_P       = 3'd4,
      CSR_RATE_I       = 3'd5,
      CSR_RATE_D       = 3'd6
   } carpid_reg_type;

   typedef struct packed {
      logic signed [15:0] target_angle;
      logic signed [23:0] angle_p_gain;
      logic signed [23:0] angle_i_gain;
      logic signed [23:0] angle_d_gain;
      logic signed [23:0] rate_p_gain;
      logic signed [23:0] rate_i_gain;
      logic signed [23:0] rate_d_gain;
   } carpid_cfg_type;

   typedef enum logic [2:0] {
      MUL_AP,
      MUL_AI,
      MUL_AD,
      MUL_RP,
      MUL_RI,
      MUL_RD
   } carpid_mul_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_ERR,
      ST_A_MP,
      ST_A_MI,
      ST_A_MD,
      ST_A_ACC,
      ST_A_OUT,
      ST_R_ERR,
      ST_R_MP,
      ST_R_MI,
      ST_R_MD,
      ST_R_ACC,
      ST_R_OUT
   } carpid_state_type;

   typedef struct packed {
      logic           load_in;
      logic           outer_err;
      logic           inner_err;
      carpid_mul_type mul_sel;
      logic           acc_add;
      logic           set_setpoint;
      logic           load_rsp;
   } carpid_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } carpid_status_type;

   function automatic logic signed [OUT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   // arithmetic shift right that rounds toward zero
   function automatic logic signed [ACC_W-1:0] shr_trunc(input logic signed [ACC_W-1:0] v,
                                                         input int unsigned sh);
      logic signed [ACC_W-1:0] bias;
      bias = v[ACC_W-1] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
      return (v + bias) >>> sh;
   endfunction

endpackage

`default_nettype wire

[rtl/carpid_csr.sv]
// ----------------------------------------------------------------------------
// carpid_csr
// Gain and target registers, written through the csr channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module carpid_csr
   import carpid_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [2:0]     csr_index,
   input  wire logic [23:0]    csr_data,
   output carpid_cfg_type      cfg
);

   carpid_cfg_type cfg_ff;
   carpid_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_ANGLE: cfg_in.target_angle = csr_data[15:0];
            CSR_ANGLE_P:      cfg_in.angle_p_gain = csr_data;
            CSR_ANGLE_I:      cfg_in.angle_i_gain = csr_data;
            CSR_ANGLE_D:      cfg_in.angle_d_gain = csr_data;
            CSR_RATE_P:       cfg_in.rate_p_gain  = csr_data;
            CSR_RATE_I:       cfg_in.rate_i_gain  = csr_data;
            CSR_RATE_D:       cfg_in.rate_d_gain  = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_angle <= TARGET_ANGLE_RST;
         cfg_ff.angle_p_gain <= ANGLE_P_RST;
         cfg_ff.angle_i_gain <= ANGLE_I_RST;
         cfg_ff.angle_d_gain <= ANGLE_D_RST;
         cfg_ff.rate_p_gain  <= RATE_P_RST;
         cfg_ff.rate_i_gain  <= RATE_I_RST;
         cfg_ff.rate_d_gain  <= RATE_D_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/carpid_ctrl.sv]
// ----------------------------------------------------------------------------
// carpid_ctrl
// Sequencer for the outer and inner loop steps on the shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module carpid_ctrl
   import carpid_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire carpid_status_type  status,
   output carpid_cmd_type          cmd
);

   carpid_state_type state_ff;
   carpid_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) begin
            state_in = ST_A_ERR;
         end
         ST_A_ERR: state_in = ST_A_MP;
         ST_A_MP:  state_in = ST_A_MI;
         ST_A_MI:  state_in = ST_A_MD;
         ST_A_MD:  state_in = ST_A_ACC;
         ST_A_ACC: state_in = ST_A_OUT;
         ST_A_OUT: state_in = ST_R_ERR;
         ST_R_ERR: state_in = ST_R_MP;
         ST_R_MP:  state_in = ST_R_MI;
         ST_R_MI:  state_in = ST_R_MD;
         ST_R_MD:  state_in = ST_R_ACC;
         ST_R_ACC: state_in = ST_R_OUT;
         ST_R_OUT: if (status.rsp_free) begin
            state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready       = 1'b0;
      cmd              = '0;
      cmd.mul_sel      = MUL_AP;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ST_A_ERR: cmd.outer_err = 1'b1;
         ST_A_MP:  cmd.mul_sel = MUL_AP;
         ST_A_MI: begin
            cmd.mul_sel = MUL_AI;
            cmd.acc_add = 1'b1;
         end
         ST_A_MD: begin
            cmd.mul_sel = MUL_AD;
            cmd.acc_add = 1'b1;
         end
         ST_A_ACC: cmd.acc_add = 1'b1;
         ST_A_OUT: cmd.set_setpoint = 1'b1;
         ST_R_ERR: cmd.inner_err = 1'b1;
         ST_R_MP:  cmd.mul_sel = MUL_RP;
         ST_R_MI: begin
            cmd.mul_sel = MUL_RI;
            cmd.acc_add = 1'b1;
         end
         ST_R_MD: begin
            cmd.mul_sel = MUL_RD;
            cmd.acc_add = 1'b1;
         end
         ST_R_ACC: cmd.acc_add = 1'b1;
         ST_R_OUT: cmd.load_rsp = status.rsp_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/carpid_dp.sv]
// ----------------------------------------------------------------------------
// carpid_dp
// Loop state, shared 24x34 multiplier, accumulator and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module carpid_dp
   import carpid_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire carpid_cmd_type     cmd,
   input  wire carpid_cfg_type     cfg,
   input  wire logic [31:0]        req_tdata,
   input  wire logic               rsp_tready,
   output logic                    rsp_tvalid,
   output logic [63:0]             rsp_tdata,
   output carpid_status_type       status
);

   logic signed [ANGLE_W-1:0] tilt_ff;
   logic signed [ANGLE_W-1:0] gyro_ff;
   logic signed [OUT_W-1:0]   asum_ff;
   logic signed [ANGLE_W-1:0] prev_angle_ff;
   logic signed [OUT_W-1:0]   rsum_ff;
   logic signed [ANGLE_W-1:0] prev_rate_ff;
   logic signed [16:0]        ea_ff;
   logic signed [16:0]        da_ff;
   logic signed [OPND_W-1:0]  er_ff;
   logic signed [16:0]        dr_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [OUT_W-1:0]   setpoint_ff;
   logic                      rsp_valid_ff;
   logic [63:0]               rsp_data_ff;

   logic signed [16:0]        ea_in;
   logic signed [OPND_W-1:0]  er_in;
   logic signed [GAIN_W-1:0]  mul_gain;
   logic signed [OPND_W-1:0]  mul_opnd;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [OUT_W-1:0]   drive_in;

   assign ea_in    = 17'(cfg.target_angle) - 17'(tilt_ff);
   assign er_in    = OPND_W'(setpoint_ff) - OPND_W'(gyro_ff) + RATE_OFFSET;
   assign prod_in  = mul_gain * mul_opnd;
   assign drive_in = sat32(shr_trunc(acc_ff, INNER_SHIFT));

   always_comb begin
      case (cmd.mul_sel)
         MUL_AP: begin
            mul_gain = cfg.angle_p_gain;
            mul_opnd = OPND_W'(ea_ff);
         end
         MUL_AI: begin
            mul_gain = cfg.angle_i_gain;
            mul_opnd = OPND_W'(asum_ff);
         end
         MUL_AD: begin
            mul_gain = cfg.angle_d_gain;
            mul_opnd = OPND_W'(da_ff);
         end
         MUL_RP: begin
            mul_gain = cfg.rate_p_gain;
            mul_opnd = er_ff;
         end
         MUL_RI: begin
            mul_gain = cfg.rate_i_gain;
            mul_opnd = OPND_W'(rsum_ff);
         end
         MUL_RD: begin
            mul_gain = cfg.rate_d_gain;
            mul_opnd = OPND_W'(dr_ff);
         end
         default: begin
            mul_gain = '0;
            mul_opnd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load_in) begin
         tilt_ff <= req_tdata[15:0];
         gyro_ff <= req_tdata[31:16];
      end
      if (cmd.outer_err) begin
         ea_ff  <= ea_in;
         da_ff  <= 17'(tilt_ff) - 17'(prev_angle_ff);
         acc_ff <= '0;
      end else if (cmd.inner_err) begin
         er_ff  <= er_in;
         dr_ff  <= 17'(gyro_ff) - 17'(prev_rate_ff);
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.set_setpoint) begin
         setpoint_ff <= sat32(shr_trunc(acc_ff, OUTER_SHIFT));
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= {setpoint_ff, drive_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asum_ff       <= '0;
         prev_angle_ff <= '0;
         rsum_ff       <= '0;
         prev_rate_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.outer_err) begin
            asum_ff       <= sat32(ACC_W'(asum_ff) + ACC_W'(ea_in));
            prev_angle_ff <= tilt_ff;
         end
         if (cmd.inner_err) begin
            rsum_ff      <= sat32(ACC_W'(rsum_ff) + ACC_W'(er_in));
            prev_rate_ff <= gyro_ff;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

[rtl/cascaded_angle_rate_pid_unit.sv]
// A response is registered on rsp_tvalid once the sequencer has run the outer angle steps
// and then the inner rate steps; a new request is taken only after the last one is done.
// The single shared 24x34 multiplier forms the six products of each tick one after another.
// A full response register holds the sequencer in its last step until taken.
// Reset (synchronous, active high) restores the gains and target and clears both
// integrators and the previous angle and rate samples.
// ----------------------------------------------------------------------------
// cascaded_angle_rate_pid_unit
// Outer angle PID feeding an inner rate PID, one request per control tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cascaded_angle_rate_pid_unit
   import carpid_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // tilt_angle[15:0], gyro_rate[31:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // drive_command[31:0], rate_setpoint[63:32]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   carpid_cfg_type    cfg;
   carpid_cmd_type    cmd;
   carpid_status_type status;

   carpid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   carpid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   carpid_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .status     (status)
   );

endmodule

`default_nettype wire

[rtl/carpid_checker.sv]
// ----------------------------------------------------------------------------
// carpid_checker
// Port-level checks of the cascaded angle/rate PID unit, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cascaded_angle_rate_pid_unit_defines.svh"

module carpid_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);

   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   `CARPID_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `CARPID_ASSERT(a_busy_after_req, req_fire |=> !req_tready, "request taken while busy")
   `CARPID_ASSERT(a_no_instant_rsp, $rose(rsp_tvalid) |-> !$past(req_fire), "response right after request")
   `CARPID_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind cascaded_angle_rate_pid_unit carpid_checker u_carpid_checker (.*);

`default_nettype wire
